// ===== rtl/multi_pump_dosing_tick_engine_macros.svh =====
// assertion macros shared by the dosing engine checkers
`ifndef MULTI_PUMP_DOSING_TICK_ENGINE_MACROS_SVH
`define MULTI_PUMP_DOSING_TICK_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MPDTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dosing engine check failed");

// next-cycle implication, disabled during reset
`define MPDTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dosing engine check failed");

`endif

// ===== rtl/mpdte_pkg.sv =====
// types, codes and sizes shared by the dosing tick engine
package mpdte_pkg;

   localparam int NUM_PUMPS = 4;
   localparam int PUMP_AW   = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;

   // item kinds
   localparam logic [2:0] KIND_TICK        = 3'd0;
   localparam logic [2:0] KIND_START_TIMED = 3'd1;
   localparam logic [2:0] KIND_START_CONT  = 3'd2;
   localparam logic [2:0] KIND_START_CAL   = 3'd3;
   localparam logic [2:0] KIND_STOP        = 3'd4;
   localparam logic [2:0] KIND_SET_TANK    = 3'd5;

   // pump modes
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_TIMED = 2'd1;
   localparam logic [1:0] MODE_CONT  = 2'd2;
   localparam logic [1:0] MODE_CAL   = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  pump;
      logic [31:0] run_ticks;
      logic [23:0] flow_per_tick;
      logic        direction;
      logic        clear_count;
      logic [31:0] tank_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  pump_res;
      logic [1:0]  mode;
      logic        direction_res;
      logic [31:0] tick_count;
      logic [31:0] dosed_volume;
      logic [31:0] tank_level;
      logic [39:0] running_total;
      logic        stopped_now;
      logic        tank_changed;
      logic        last;
   } rsp_type;

   // one pump record as held in the record memory
   typedef struct packed {
      logic [1:0]  mode;
      logic        direction;
      logic [31:0] count;
      logic [23:0] flow;
      logic [31:0] dosed;
      logic [31:0] tank;
      logic [39:0] running;
   } rec_type;

   // per-visit status from the record update
   typedef struct packed {
      logic stopped;
      logic changed;
   } flags_type;

endpackage

// ===== rtl/multi_pump_dosing_tick_engine.sv =====
// Dosing tick engine: keeps one record per pump in a small synchronous memory.
// A tick item reads, updates and writes back every pump record in index order
// and returns one item per pump (last set on the final one); a command item
// touches the addressed pump and returns one item. The memory has a single
// read port, so a tick walks the pumps one per cycle while the update stage
// can advance; the held input item is released only after its last read is
// issued, so a new input item is not taken before then. The first result
// passes through the held item register, the registered read and update
// stage, and the output register. A full output register that is not being
// taken stalls the engine, and the next input item is taken while earlier
// results are still being worked on or wait. Records read as zero until first written after reset.
module multi_pump_dosing_tick_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mpdte_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mpdte_pkg::rsp_type  rsp_data
);

   localparam int AW = mpdte_pkg::PUMP_AW;
   localparam int NP = mpdte_pkg::NUM_PUMPS;

   // held input item and tick walk index
   logic               item_valid_ff, item_valid_in;
   mpdte_pkg::req_type item_ff;
   logic [AW-1:0]      idx_ff, idx_in;

   // update stage
   logic               exec_valid_ff, exec_valid_in;
   mpdte_pkg::req_type exec_item_ff;
   logic [AW-1:0]      exec_addr_ff;
   logic [1:0]         exec_pump_ff;
   logic               exec_tick_ff;
   logic               exec_last_ff;
   logic               exec_oor_ff;

   // record memory and read side
   mpdte_pkg::rec_type rec_mem [NP];
   logic [NP-1:0]      rec_valid_ff, rec_valid_in;
   mpdte_pkg::rec_type rd_raw_ff;
   logic               rd_vld_ff;
   logic               fwd_ff;
   mpdte_pkg::rec_type fwd_data_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   mpdte_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               exec_fire;
   logic               issue;
   logic               item_tick;
   logic               item_oor;
   logic               issue_last;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   mpdte_pkg::rec_type rec_cur;
   mpdte_pkg::rec_type rec_new;
   mpdte_pkg::flags_type upd_flags;

   assign req_ready = !item_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // issue and advance control
   assign exec_fire  = exec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue      = item_valid_ff && (!exec_valid_ff || exec_fire);
   assign item_tick  = (item_ff.kind == mpdte_pkg::KIND_TICK);
   assign item_oor   = !item_tick && (32'(item_ff.pump) >= 32'(NP));
   assign issue_last = !item_tick || (idx_ff == AW'(NP - 1));
   assign rd_addr    = item_tick ? idx_ff : (item_oor ? '0 : AW'(item_ff.pump));
   assign wr_en      = exec_fire && !exec_oor_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      idx_in        = idx_ff;
      if (issue) begin
         if (issue_last) begin
            item_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + AW'(1);
         end
      end
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         idx_in        = '0;
      end
   end

   always_comb begin
      exec_valid_in = exec_valid_ff;
      if (exec_fire) begin
         exec_valid_in = 1'b0;
      end
      if (issue) begin
         exec_valid_in = 1'b1;
      end
   end

   always_comb begin
      rec_valid_in = rec_valid_ff;
      if (wr_en) begin
         rec_valid_in[exec_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
         exec_valid_ff <= 1'b0;
         rec_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         exec_valid_ff <= exec_valid_in;
         rec_valid_ff  <= rec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // item and update-stage payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (issue) begin
         exec_item_ff <= item_ff;
         exec_addr_ff <= rd_addr;
         exec_pump_ff <= item_tick ? 2'(idx_ff) : item_ff.pump;
         exec_tick_ff <= item_tick;
         exec_last_ff <= issue_last;
         exec_oor_ff  <= item_oor;
      end
   end

   // record memory, write port and registered read port with forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[exec_addr_ff] <= rec_new;
      end
      if (issue) begin
         rd_raw_ff   <= rec_mem[rd_addr];
         rd_vld_ff   <= rec_valid_ff[rd_addr];
         fwd_ff      <= wr_en && (exec_addr_ff == rd_addr);
         fwd_data_ff <= rec_new;
      end
   end

   assign rec_cur = fwd_ff ? fwd_data_ff : (rd_vld_ff ? rd_raw_ff : '0);

   mpdte_pump_update u_update (
      .rec_i (rec_cur),
      .item  (exec_item_ff),
      .tick  (exec_tick_ff),
      .rec_o (rec_new),
      .flags (upd_flags)
   );

   // result formatting into the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end
      rsp_data_in = '0;
      rsp_data_in.pump_res = exec_pump_ff;
      rsp_data_in.last     = exec_last_ff;
      if (!exec_oor_ff) begin
         rsp_data_in.mode          = rec_new.mode;
         rsp_data_in.direction_res = rec_new.direction;
         rsp_data_in.tick_count    = rec_new.count;
         rsp_data_in.dosed_volume  = rec_new.dosed;
         rsp_data_in.tank_level    = rec_new.tank;
         rsp_data_in.running_total = rec_new.running;
         rsp_data_in.stopped_now   = upd_flags.stopped;
         rsp_data_in.tank_changed  = upd_flags.changed;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/mpdte_pump_update.sv =====
// record update for one pump visit: tick delivery or command
module mpdte_pump_update (
   input  mpdte_pkg::rec_type   rec_i,
   input  mpdte_pkg::req_type   item,
   input  logic                 tick,
   output mpdte_pkg::rec_type   rec_o,
   output mpdte_pkg::flags_type flags
);

   logic [31:0] flow_ext;
   logic [32:0] dosed_sum;

   // saturating dose add, clamped tank subtract, saturating counters, mode transitions
   always_comb begin
      rec_o     = rec_i;
      flags     = '0;
      flow_ext  = {8'd0, rec_i.flow};
      dosed_sum = {1'b0, rec_i.dosed} + {1'b0, flow_ext};
      if (tick) begin
         if ((rec_i.mode == mpdte_pkg::MODE_TIMED && rec_i.count != '0) ||
             rec_i.mode == mpdte_pkg::MODE_CONT) begin
            rec_o.dosed = dosed_sum[32] ? '1 : dosed_sum[31:0];
            rec_o.tank  = (rec_i.tank > flow_ext) ? (rec_i.tank - flow_ext) : '0;
            if (rec_i.running != '1) begin
               rec_o.running = rec_i.running + 40'd1;
            end
            flags.changed = 1'b1;
            if (rec_i.mode == mpdte_pkg::MODE_TIMED) begin
               rec_o.count = rec_i.count - 32'd1;
               if (rec_i.count == 32'd1) begin
                  rec_o.mode    = mpdte_pkg::MODE_OFF;
                  flags.stopped = 1'b1;
               end
            end
         end else if (rec_i.mode == mpdte_pkg::MODE_CAL) begin
            if (rec_i.count != '1) begin
               rec_o.count = rec_i.count + 32'd1;
            end
         end
      end else begin
         case (item.kind)
            mpdte_pkg::KIND_START_TIMED: begin
               rec_o.count     = (item.run_ticks == '0) ? 32'd1 : item.run_ticks;
               rec_o.flow      = item.flow_per_tick;
               rec_o.dosed     = '0;
               rec_o.direction = item.direction;
               rec_o.mode      = mpdte_pkg::MODE_TIMED;
            end
            mpdte_pkg::KIND_START_CONT: begin
               rec_o.flow      = item.flow_per_tick;
               rec_o.dosed     = '0;
               rec_o.direction = item.direction;
               rec_o.mode      = mpdte_pkg::MODE_CONT;
            end
            mpdte_pkg::KIND_START_CAL: begin
               rec_o.count     = '0;
               rec_o.flow      = '0;
               rec_o.dosed     = '0;
               rec_o.direction = item.direction;
               rec_o.mode      = mpdte_pkg::MODE_CAL;
            end
            mpdte_pkg::KIND_STOP: begin
               rec_o.mode = mpdte_pkg::MODE_OFF;
               if (item.clear_count) begin
                  rec_o.count = '0;
               end
            end
            mpdte_pkg::KIND_SET_TANK: begin
               rec_o.tank = item.tank_value;
            end
            default: begin
               // status read, record unchanged
            end
         endcase
      end
   end

endmodule

// ===== rtl/mpdte_checker.sv =====
// port-level checks for the dosing tick engine and their bind
`include "multi_pump_dosing_tick_engine_macros.svh"

module mpdte_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mpdte_pkg::rsp_type rsp_data
);

   // a waiting result item holds
   `MPDTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // a timed run that ends leaves the pump off with no ticks left
   `MPDTE_ASSERT_NOW(a_stop_off, clock, reset, rsp_valid && rsp_data.stopped_now, rsp_data.mode == mpdte_pkg::MODE_OFF && rsp_data.tick_count == '0)

   // an ending run delivered flow on that tick
   `MPDTE_ASSERT_NOW(a_stop_flow, clock, reset, rsp_valid && rsp_data.stopped_now, rsp_data.tank_changed)

   // flow only from a running pump or one that just stopped
   `MPDTE_ASSERT_NOW(a_flow_mode, clock, reset, rsp_valid && rsp_data.tank_changed, rsp_data.mode == mpdte_pkg::MODE_TIMED || rsp_data.mode == mpdte_pkg::MODE_CONT || rsp_data.stopped_now)

   // a result for the highest pump always carries last
   `MPDTE_ASSERT_NOW(a_not_last, clock, reset, rsp_valid && !rsp_data.last, rsp_data.pump_res != 2'(mpdte_pkg::NUM_PUMPS - 1))

endmodule

bind multi_pump_dosing_tick_engine mpdte_checker u_mpdte_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the multi-pump dosing tick engine
`timescale 1ns / 1ps

module testbench;

   // spare kind codes, answered with a plain status item
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   localparam logic [31:0] VOL_MAX  = 32'hFFFF_FFFF;
   localparam logic [39:0] RUN_MAX  = 40'hFF_FFFF_FFFF;
   localparam logic [23:0] FLOW_MAX = 24'hFF_FFFF;
   localparam int          NP       = mpdte_pkg::NUM_PUMPS;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   mpdte_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   mpdte_pkg::rsp_type rsp_data;

   // predicted pump records
   logic [1:0]  pump_mode  [NP];
   logic        pump_dir   [NP];
   logic [31:0] pump_count [NP];
   logic [23:0] pump_flow  [NP];
   logic [31:0] pump_dosed [NP];
   logic [31:0] pump_tank  [NP];
   logic [39:0] pump_run   [NP];

   mpdte_pkg::rsp_type pump_reports[$];
   int                 mismatch_count = 0;
   int                 send_idle_pct  = 0;
   int                 stall_pct      = 0;

   multi_pump_dosing_tick_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock, 12 ns period
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // snapshot of one pump record as the engine reports it
   function automatic mpdte_pkg::rsp_type pump_report(input int p, input logic stopped,
                                                      input logic changed,
                                                      input logic last_flag);
      mpdte_pkg::rsp_type r;
      r.pump_res      = 2'(p);
      r.mode          = pump_mode[p];
      r.direction_res = pump_dir[p];
      r.tick_count    = pump_count[p];
      r.dosed_volume  = pump_dosed[p];
      r.tank_level    = pump_tank[p];
      r.running_total = pump_run[p];
      r.stopped_now   = stopped;
      r.tank_changed  = changed;
      r.last          = last_flag;
      return r;
   endfunction

   // one tick of flow: saturating dose and running total, tank clamped at zero
   task automatic deliver_flow(input int p);
      logic [32:0] sum;
      sum = {1'b0, pump_dosed[p]} + {9'd0, pump_flow[p]};
      pump_dosed[p] = sum[32] ? VOL_MAX : sum[31:0];
      pump_tank[p]  = (pump_tank[p] > {8'd0, pump_flow[p]}) ?
                      pump_tank[p] - {8'd0, pump_flow[p]} : 32'd0;
      if (pump_run[p] != RUN_MAX) pump_run[p] = pump_run[p] + 40'd1;
   endtask

   // advance the predicted records by one item and queue its reports
   task automatic predict_dosing(input mpdte_pkg::req_type item);
      int                 p;
      logic               stopped;
      logic               changed;
      mpdte_pkg::rsp_type blank;
      if (item.kind == mpdte_pkg::KIND_TICK) begin
         for (int i = 0; i < NP; i++) begin
            stopped = 1'b0;
            changed = 1'b0;
            if (pump_mode[i] == mpdte_pkg::MODE_TIMED && pump_count[i] != 32'd0) begin
               deliver_flow(i);
               changed = 1'b1;
               pump_count[i] = pump_count[i] - 32'd1;
               if (pump_count[i] == 32'd0) begin
                  pump_mode[i] = mpdte_pkg::MODE_OFF;
                  stopped = 1'b1;
               end
            end else if (pump_mode[i] == mpdte_pkg::MODE_CONT) begin
               deliver_flow(i);
               changed = 1'b1;
            end else if (pump_mode[i] == mpdte_pkg::MODE_CAL) begin
               if (pump_count[i] != VOL_MAX) pump_count[i] = pump_count[i] + 32'd1;
            end
            pump_reports.push_back(pump_report(i, stopped, changed, i == NP - 1));
         end
         return;
      end
      p = int'(item.pump);
      if (p >= NP) begin
         blank          = '0;
         blank.pump_res = item.pump;
         blank.last     = 1'b1;
         pump_reports.push_back(blank);
         return;
      end
      case (item.kind)
         mpdte_pkg::KIND_START_TIMED: begin
            pump_count[p] = (item.run_ticks == 32'd0) ? 32'd1 : item.run_ticks;
            pump_flow[p]  = item.flow_per_tick;
            pump_dosed[p] = '0;
            pump_dir[p]   = item.direction;
            pump_mode[p]  = mpdte_pkg::MODE_TIMED;
         end
         mpdte_pkg::KIND_START_CONT: begin
            pump_flow[p]  = item.flow_per_tick;
            pump_dosed[p] = '0;
            pump_dir[p]   = item.direction;
            pump_mode[p]  = mpdte_pkg::MODE_CONT;
         end
         mpdte_pkg::KIND_START_CAL: begin
            pump_count[p] = '0;
            pump_flow[p]  = '0;
            pump_dosed[p] = '0;
            pump_dir[p]   = item.direction;
            pump_mode[p]  = mpdte_pkg::MODE_CAL;
         end
         mpdte_pkg::KIND_STOP: begin
            pump_mode[p] = mpdte_pkg::MODE_OFF;
            if (item.clear_count) pump_count[p] = '0;
         end
         mpdte_pkg::KIND_SET_TANK: begin
            pump_tank[p] = item.tank_value;
         end
         default: ;
      endcase
      pump_reports.push_back(pump_report(p, 1'b0, 1'b0, 1'b1));
   endtask

   task automatic check_field(input string name, input logic [39:0] want,
                              input logic [39:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      mpdte_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pump_reports.size() == 0) begin
            $error("unexpected result item for pump %0d", rsp_data.pump_res);
            mismatch_count++;
         end else begin
            want = pump_reports.pop_front();
            check_field("pump_res", want.pump_res, rsp_data.pump_res);
            check_field("mode", want.mode, rsp_data.mode);
            check_field("direction_res", want.direction_res, rsp_data.direction_res);
            check_field("tick_count", want.tick_count, rsp_data.tick_count);
            check_field("dosed_volume", want.dosed_volume, rsp_data.dosed_volume);
            check_field("tank_level", want.tank_level, rsp_data.tank_level);
            check_field("running_total", want.running_total, rsp_data.running_total);
            check_field("stopped_now", want.stopped_now, rsp_data.stopped_now);
            check_field("tank_changed", want.tank_changed, rsp_data.tank_changed);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   // drive one item, idling first at random; returns at the accepting edge
   task automatic send_item(input mpdte_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (req_ready !== 1'b1);
      predict_dosing(item);
   endtask

   // drop valid and hold off until every predicted result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pump_reports.size() != 0) @(posedge clock);
   endtask

   function automatic mpdte_pkg::req_type make_item(input logic [2:0] kind, input int p,
                                                    input logic [31:0] ticks,
                                                    input logic [23:0] flow,
                                                    input logic dir, input logic clr,
                                                    input logic [31:0] tank);
      mpdte_pkg::req_type item;
      item.kind          = kind;
      item.pump          = 2'(p);
      item.run_ticks     = ticks;
      item.flow_per_tick = flow;
      item.direction     = dir;
      item.clear_count   = clr;
      item.tank_value    = tank;
      return item;
   endfunction

   // mostly real dosing traffic with random content, some spare kinds
   function automatic mpdte_pkg::req_type random_item();
      mpdte_pkg::req_type item;
      int                 sel;
      item.pump          = 2'($urandom_range(0, 3));
      item.run_ticks     = $urandom;
      item.flow_per_tick = 24'($urandom);
      item.direction     = 1'($urandom);
      item.clear_count   = 1'($urandom);
      item.tank_value    = $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 42)      item.kind = mpdte_pkg::KIND_TICK;
      else if (sel < 57) item.kind = mpdte_pkg::KIND_START_TIMED;
      else if (sel < 67) item.kind = mpdte_pkg::KIND_START_CONT;
      else if (sel < 75) item.kind = mpdte_pkg::KIND_START_CAL;
      else if (sel < 85) item.kind = mpdte_pkg::KIND_STOP;
      else if (sel < 95) item.kind = mpdte_pkg::KIND_SET_TANK;
      else if (sel < 97) item.kind = KIND_SPARE_LO;
      else               item.kind = KIND_SPARE_HI;
      // short timed runs so that most of them end inside the run
      if (item.kind == mpdte_pkg::KIND_START_TIMED) begin
         case ($urandom_range(0, 9))
            0:       item.run_ticks = '0;
            1:       item.run_ticks = $urandom;
            default: item.run_ticks = $urandom_range(1, 12);
         endcase
      end
      // small tank levels now and then, so clamping happens
      if (item.kind == mpdte_pkg::KIND_SET_TANK && $urandom_range(0, 2) == 0)
         item.tank_value = $urandom_range(0, 32'h0004_0000);
      return item;
   endfunction

   // status reads and a tick straight after reset
   task automatic test_reset_state();
      send_item(make_item(KIND_SPARE_LO, 0, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(KIND_SPARE_HI, 3, VOL_MAX, FLOW_MAX, 1'b1, 1'b1, VOL_MAX));
      send_item(make_item(mpdte_pkg::KIND_TICK, 2, '0, '0, 1'b0, 1'b0, '0));
   endtask

   // timed runs: zero length, tank clamp, stop keeping and clearing the count
   task automatic test_timed_runs();
      send_item(make_item(mpdte_pkg::KIND_START_TIMED, 0, '0, FLOW_MAX, 1'b1, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_TICK, 0, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_SET_TANK, 1, '0, '0, 1'b0, 1'b0, 32'h0001_0000));
      send_item(make_item(mpdte_pkg::KIND_START_TIMED, 1, 32'd3, 24'h00_C000, 1'b0, 1'b0,
                          '0));
      repeat (3) send_item(make_item(mpdte_pkg::KIND_TICK, 1, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_START_TIMED, 2, VOL_MAX, 24'd1, 1'b1, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_TICK, 0, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_STOP, 2, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_START_CONT, 2, '0, 24'h80_0000, 1'b1, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_TICK, 0, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_STOP, 2, '0, '0, 1'b0, 1'b1, '0));
   endtask

   // calibration counts up and survives a stop that keeps the count
   task automatic test_calibration();
      send_item(make_item(mpdte_pkg::KIND_START_CAL, 3, '0, FLOW_MAX, 1'b1, 1'b0, '0));
      repeat (2) send_item(make_item(mpdte_pkg::KIND_TICK, 0, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_STOP, 3, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(KIND_SPARE_LO, 3, '0, '0, 1'b0, 1'b0, '0));
   endtask

   // tank loads at both extremes
   task automatic test_tank_extremes();
      send_item(make_item(mpdte_pkg::KIND_SET_TANK, 0, '0, '0, 1'b0, 1'b0, VOL_MAX));
      send_item(make_item(mpdte_pkg::KIND_SET_TANK, 3, '0, '0, 1'b0, 1'b0, '0));
   endtask

   // full flow for long enough that the dosed volume saturates
   task automatic test_dosed_saturation();
      send_idle_pct = 21;
      stall_pct     = 21;
      send_item(make_item(mpdte_pkg::KIND_START_CONT, 1, '0, FLOW_MAX, 1'b0, 1'b0, '0));
      repeat (260) send_item(make_item(mpdte_pkg::KIND_TICK, 0, '0, '0, 1'b0, 1'b0, '0));
      send_item(make_item(mpdte_pkg::KIND_STOP, 1, '0, '0, 1'b0, 1'b1, '0));
      wait_drained();
   endtask

   // random traffic under one idling and stall setting, draining now and then
   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 3) wait_drained();
         send_item(random_item());
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < NP; i++) begin
         pump_mode[i]  = mpdte_pkg::MODE_OFF;
         pump_dir[i]   = 1'b0;
         pump_count[i] = '0;
         pump_flow[i]  = '0;
         pump_dosed[i] = '0;
         pump_tank[i]  = '0;
         pump_run[i]   = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_timed_runs();
      test_calibration();
      test_tank_extremes();
      wait_drained();
      test_dosed_saturation();
      test_random_traffic(12, 0, 0);
      test_random_traffic(12, 50, 0);
      test_random_traffic(12, 0, 50);
      test_random_traffic(12, 21, 21);

      // let any stray result show up before the verdict
      wait_drained();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
